>>> design/prc_pkg.sv
// Shared types, codes and constants for the pixel radiometric calibration block.
package prc_pkg;

    // Table sizes
    localparam int SAMPLES_DEFAULT = 2048;
    localparam int LINES_DEFAULT   = 32768;

    // Field widths
    localparam int SIDX_W = 11;
    localparam int LIDX_W = 15;
    localparam int DN_W   = 16;
    localparam int COEF_W = 24;
    localparam int ENTRY_W = 2 * COEF_W;
    localparam int SCALE_W = 32;
    localparam int VALUE_W = 32;
    localparam int CFG_IDX_W = 1;

    // Request kinds carried in tuser
    localparam logic [1:0] REQ_PIXEL  = 2'd0;
    localparam logic [1:0] REQ_SAMPLE = 2'd1;
    localparam logic [1:0] REQ_LINE   = 2'd2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_OUTPUT_SCALE   = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LAST_GOOD_LINE = 1'd1;

    // Configuration reset values
    localparam logic [SCALE_W-1:0] OUTPUT_SCALE_RESET   = 32'h0001_0000;
    localparam logic [LIDX_W-1:0]  LAST_GOOD_LINE_RESET = 15'h7FFF;

    // Rounding constant for a shift right by 16
    localparam logic [15:0] HALF_LSB = 16'h8000;

    // Item that enters the arithmetic pipeline alongside the table read
    typedef struct packed {
        logic            valid;
        logic            special;
        logic            s_ok;
        logic            l_ok;
        logic [DN_W-1:0] dn;
    } prc_ctrl_t;

    // Tag that travels with an item through the arithmetic stages
    typedef struct packed {
        logic            valid;
        logic            special;
        logic            neg;
        logic [DN_W-1:0] dn;
    } prc_tag_t;

endpackage

>>> design/prc_coef_mem.sv
// Sample and line coefficient memories, one entry holds offset and gain.
module prc_coef_mem #(
    parameter int SAMPLES = prc_pkg::SAMPLES_DEFAULT,
    parameter int LINES   = prc_pkg::LINES_DEFAULT,
    parameter int SAW     = (SAMPLES > 1) ? $clog2(SAMPLES) : 1,
    parameter int LAW     = (LINES > 1) ? $clog2(LINES) : 1
) (
    input  logic                         clk,
    input  logic                         rd_en,
    input  logic                         s_wr,
    input  logic                         l_wr,
    input  logic [SAW-1:0]               s_addr,
    input  logic [LAW-1:0]               l_addr,
    input  logic [prc_pkg::ENTRY_W-1:0]  wdata,
    output logic [prc_pkg::ENTRY_W-1:0]  s_rdata,
    output logic [prc_pkg::ENTRY_W-1:0]  l_rdata
);

    logic [prc_pkg::ENTRY_W-1:0] s_mem [SAMPLES];
    logic [prc_pkg::ENTRY_W-1:0] l_mem [LINES];
    logic [prc_pkg::ENTRY_W-1:0] s_rdata_reg;
    logic [prc_pkg::ENTRY_W-1:0] l_rdata_reg;

    // Write a loaded entry, read the addressed entry when the pipe advances
    always_ff @(posedge clk)
    begin
        if (s_wr)
        begin
            s_mem[s_addr] <= wdata;
        end
        if (rd_en)
        begin
            s_rdata_reg <= s_mem[s_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (l_wr)
        begin
            l_mem[l_addr] <= wdata;
        end
        if (rd_en)
        begin
            l_rdata_reg <= l_mem[l_addr];
        end
    end

    assign s_rdata = s_rdata_reg;
    assign l_rdata = l_rdata_reg;

endmodule

>>> design/prc_calc.sv
// Arithmetic pipeline: offset subtract, three rounded multiplies, saturation.
module prc_calc (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          en,
    input  prc_pkg::prc_ctrl_t            ctrl,
    input  logic [prc_pkg::ENTRY_W-1:0]   s_entry,
    input  logic [prc_pkg::ENTRY_W-1:0]   l_entry,
    input  logic [prc_pkg::SCALE_W-1:0]   scale,
    output logic                          res_valid,
    output logic                          res_special,
    output logic [prc_pkg::VALUE_W-1:0]   res_value
);

    localparam int CW = prc_pkg::COEF_W;

    // Stage tags (fixed place per stage)
    prc_pkg::prc_tag_t tag1_reg, tag2_reg, tag3_reg, tag4_reg, tag5_reg, tag6_reg, tag7_reg;

    // Stage 1: |d| and coefficients
    logic [25:0]   mag_reg;
    logic [CW-1:0] lg1_reg, sg1_reg;
    // Stage 2: |d| * line gain
    logic [49:0]   p1_reg;
    logic [CW-1:0] sg2_reg;
    // Stage 3: m1
    logic [32:0]   m1_reg;
    logic [CW-1:0] sg3_reg;
    // Stage 4: m1 * sample gain
    logic [56:0]   p2_reg;
    // Stage 5: m2
    logic [40:0]   m2_reg;
    // Stage 6: scale partial products
    logic [47:0]   phi_reg;
    logic [56:0]   plw_reg;
    logic          big6_reg;
    // Stage 7: rounded low partial
    logic [47:0]   phi7_reg;
    logic [40:0]   rlw_reg;
    logic          big7_reg;

    logic signed [CW-1:0] so, lo;
    logic [CW-1:0]        sg, lg;
    logic signed [26:0]   d;
    logic [26:0]          d_abs;
    logic [49:0]          m1_sum;
    logic [56:0]          m2_sum;
    logic [56:0]          rlw_sum;
    logic [48:0]          m3;
    logic [15:0]          hi, lw;
    prc_pkg::prc_tag_t    tag1_next;

    assign hi = scale[31:16];
    assign lw = scale[15:0];

    // Zero coefficients of an index past the end of a table
    always_comb
    begin
        so = ctrl.s_ok ? s_entry[CW-1:0] : '0;
        sg = ctrl.s_ok ? s_entry[2*CW-1:CW] : '0;
        lo = ctrl.l_ok ? l_entry[CW-1:0] : '0;
        lg = ctrl.l_ok ? l_entry[2*CW-1:CW] : '0;
        d  = $signed({3'b000, ctrl.dn, 8'h00})
           - $signed({{3{lo[CW-1]}}, lo})
           - $signed({{3{so[CW-1]}}, so});
        d_abs = d[26] ? (27'd0 - d) : d;
        tag1_next.valid   = ctrl.valid;
        tag1_next.special = ctrl.special;
        tag1_next.neg     = d[26];
        tag1_next.dn      = ctrl.dn;
    end

    assign m1_sum  = p1_reg + {34'd0, prc_pkg::HALF_LSB};
    assign m2_sum  = p2_reg + {41'd0, prc_pkg::HALF_LSB};
    assign rlw_sum = plw_reg + {41'd0, prc_pkg::HALF_LSB};

    // Advance tags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tag1_reg <= '0;
            tag2_reg <= '0;
            tag3_reg <= '0;
            tag4_reg <= '0;
            tag5_reg <= '0;
            tag6_reg <= '0;
            tag7_reg <= '0;
        end
        else if (en)
        begin
            tag1_reg <= tag1_next;
            tag2_reg <= tag1_reg;
            tag3_reg <= tag2_reg;
            tag4_reg <= tag3_reg;
            tag5_reg <= tag4_reg;
            tag6_reg <= tag5_reg;
            tag7_reg <= tag6_reg;
        end
    end

    // Advance payload
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            mag_reg  <= d_abs[25:0];
            lg1_reg  <= lg;
            sg1_reg  <= sg;
            p1_reg   <= {24'd0, mag_reg} * {26'd0, lg1_reg};
            sg2_reg  <= sg1_reg;
            m1_reg   <= m1_sum[48:16];
            sg3_reg  <= sg2_reg;
            p2_reg   <= {24'd0, m1_reg} * {33'd0, sg3_reg};
            m2_reg   <= m2_sum[56:16];
            big6_reg <= (|m2_reg[40:32]) && (|hi);
            phi_reg  <= {16'd0, m2_reg[31:0]} * {32'd0, hi};
            plw_reg  <= {16'd0, m2_reg} * {41'd0, lw};
            phi7_reg <= phi_reg;
            rlw_reg  <= rlw_sum[56:16];
            big7_reg <= big6_reg;
        end
    end

    // Combine, saturate and sign the result; a special item passes its zero-extended raw value
    assign m3 = {1'b0, phi7_reg} + {8'd0, rlw_reg};

    always_comb
    begin
        res_valid   = tag7_reg.valid;
        res_special = tag7_reg.special;
        if (tag7_reg.special)
        begin
            res_value = {16'd0, tag7_reg.dn};
        end
        else if (tag7_reg.neg)
        begin
            if (big7_reg || (m3 > 49'h0_8000_0000))
            begin
                res_value = 32'h8000_0000;
            end
            else
            begin
                res_value = 32'd0 - m3[31:0];
            end
        end
        else
        begin
            if (big7_reg || (m3 > 49'h0_7FFF_FFFF))
            begin
                res_value = 32'h7FFF_FFFF;
            end
            else
            begin
                res_value = m3[31:0];
            end
        end
    end

endmodule

>>> design/pixel_radiometric_calibration.sv
// Top level: stream ports, configuration registers, table access, output register.
// A pixel result goes from acceptance through the table read, the 7 arithmetic stages and the output register.
// Throughput: one item per cycle; the whole pipe holds only while a result waits at the output.
// Load items write a table entry at acceptance when the index is in range, and give no result.
// Reset clears the pipe valid bits and loads output_scale = 1.0, last_good_line = 32767;
// table contents are undefined until loaded, no clearing pass is run.
module pixel_radiometric_calibration #(
    parameter int SAMPLES = prc_pkg::SAMPLES_DEFAULT,
    parameter int LINES   = prc_pkg::LINES_DEFAULT
) (
    input  logic                            clk,
    input  logic                            rst_n,
    // Configuration write port
    input  logic                            cfg_we,
    input  logic [prc_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [prc_pkg::SCALE_W-1:0]     cfg_data,
    // Input stream
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // sample_index[10:0], line_index[25:11], raw_dn[41:26], offset_word[65:42],
    // gain_word[89:66], zero fill [95:90]
    input  logic [95:0]                     s_tdata,
    // req_type[1:0], is_special[2]
    input  logic [2:0]                      s_tuser,
    // Output stream
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // calibrated_value[31:0]
    output logic [31:0]                     m_tdata,
    // passed_special[0]
    output logic                            m_tuser
);

    localparam int SAW = (SAMPLES > 1) ? $clog2(SAMPLES) : 1;
    localparam int LAW = (LINES > 1) ? $clog2(LINES) : 1;

    logic [prc_pkg::SCALE_W-1:0]  output_scale_reg;
    logic [prc_pkg::LIDX_W-1:0]   last_good_line_reg;

    logic [1:0]                   req_type;
    logic [prc_pkg::SIDX_W-1:0]   sample_index;
    logic [prc_pkg::LIDX_W-1:0]   line_index;
    logic [prc_pkg::DN_W-1:0]     raw_dn;
    logic                         is_special;
    logic [prc_pkg::COEF_W-1:0]   offset_word;
    logic [prc_pkg::COEF_W-1:0]   gain_word;

    logic                         en;
    logic                         accept;
    logic [prc_pkg::LIDX_W-1:0]   l_sel;
    logic [31:0]                  s_ext, l_ext;
    logic                         s_ok, l_ok;
    prc_pkg::prc_ctrl_t           ctrl_reg, ctrl_next;
    logic [prc_pkg::ENTRY_W-1:0]  s_entry, l_entry;

    logic                         res_valid, res_special;
    logic [prc_pkg::VALUE_W-1:0]  res_value;
    logic                         out_valid_reg;
    logic                         out_special_reg;
    logic [prc_pkg::VALUE_W-1:0]  out_value_reg;

    // Unpack the input item
    assign req_type     = s_tuser[1:0];
    assign is_special   = s_tuser[2];
    assign sample_index = s_tdata[10:0];
    assign line_index   = s_tdata[25:11];
    assign raw_dn       = s_tdata[41:26];
    assign offset_word  = s_tdata[65:42];
    assign gain_word    = s_tdata[89:66];

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            output_scale_reg   <= prc_pkg::OUTPUT_SCALE_RESET;
            last_good_line_reg <= prc_pkg::LAST_GOOD_LINE_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                prc_pkg::CFG_OUTPUT_SCALE:   output_scale_reg   <= cfg_data;
                prc_pkg::CFG_LAST_GOOD_LINE: last_good_line_reg <= cfg_data[14:0];
                default: ;
            endcase
        end
    end

    // Pipe advances unless a result is stuck at the output
    assign en       = !out_valid_reg || m_tready;
    assign s_tready = en;
    assign accept   = s_tvalid && en;

    // Clamp the line of a pixel, range-check both table indexes
    always_comb
    begin
        if ((req_type == prc_pkg::REQ_PIXEL) && (line_index > last_good_line_reg))
        begin
            l_sel = last_good_line_reg;
        end
        else
        begin
            l_sel = line_index;
        end
        s_ext = 32'(sample_index);
        l_ext = 32'(l_sel);
        s_ok  = s_ext < 32'(SAMPLES);
        l_ok  = l_ext < 32'(LINES);
        ctrl_next.valid   = accept && (req_type == prc_pkg::REQ_PIXEL);
        ctrl_next.special = is_special;
        ctrl_next.s_ok    = s_ok;
        ctrl_next.l_ok    = l_ok;
        ctrl_next.dn      = raw_dn;
    end

    // Hold the item beside the table read
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctrl_reg <= '0;
        end
        else if (en)
        begin
            ctrl_reg <= ctrl_next;
        end
    end

    prc_coef_mem #(
        .SAMPLES (SAMPLES),
        .LINES   (LINES),
        .SAW     (SAW),
        .LAW     (LAW)
    ) u_mem (
        .clk     (clk),
        .rd_en   (en),
        .s_wr    (accept && (req_type == prc_pkg::REQ_SAMPLE) && s_ok),
        .l_wr    (accept && (req_type == prc_pkg::REQ_LINE) && l_ok),
        .s_addr  (s_ext[SAW-1:0]),
        .l_addr  (l_ext[LAW-1:0]),
        .wdata   ({gain_word, offset_word}),
        .s_rdata (s_entry),
        .l_rdata (l_entry)
    );

    prc_calc u_calc (
        .clk         (clk),
        .rst_n       (rst_n),
        .en          (en),
        .ctrl        (ctrl_reg),
        .s_entry     (s_entry),
        .l_entry     (l_entry),
        .scale       (output_scale_reg),
        .res_valid   (res_valid),
        .res_special (res_special),
        .res_value   (res_value)
    );

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            out_valid_reg <= res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_special_reg <= res_special;
            out_value_reg   <= res_value;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_value_reg;
    assign m_tuser  = out_special_reg;

    // A passed-through pixel carries a zero-extended raw value
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser) |-> (m_tdata[31:16] == 16'd0))
        else $error("special pixel result has nonzero upper bits");

    // Table read data and its item hold while the pipe is stalled (unloaded entries read as X)
    assert property (@(posedge clk) disable iff (!rst_n)
        !en |=> ((ctrl_reg === $past(ctrl_reg)) && (s_entry === $past(s_entry))
                 && (l_entry === $past(l_entry))))
        else $error("stage beside table read changed during a stall");

    // A load or an idle cycle never starts a result
    assert property (@(posedge clk) disable iff (!rst_n)
        (en && !(accept && (req_type == prc_pkg::REQ_PIXEL))) |=> !ctrl_reg.valid)
        else $error("pipe entry marked valid without an accepted pixel");

    // A result enters the output register only from the last stage
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(res_valid))
        else $error("output became valid without a finished item");

endmodule

>>> sim/pixel_radiometric_calibration_test.sv
// Stream testbench for the pixel radiometric calibration block with a built-in calibration predictor.
`timescale 1ns / 100ps

module pixel_radiometric_calibration_test;

    localparam int SAMPLE_COUNT = prc_pkg::SAMPLES_DEFAULT;
    localparam int LINE_COUNT   = prc_pkg::LINES_DEFAULT;
    localparam logic [1:0] REQ_UNUSED = 2'd3;
    localparam int DRAIN_CYCLES = 16;
    localparam int QUIET_LIMIT  = 2000;

    typedef struct {
        logic [1:0]  req;
        logic [10:0] s;
        logic [14:0] l;
        logic [15:0] dn;
        logic        special;
        logic [23:0] offw;
        logic [23:0] gainw;
    } cal_item_t;

    typedef struct {
        logic [31:0] value;
        logic        special;
    } cal_result_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic [prc_pkg::CFG_IDX_W-1:0] cfg_index = '0;
    logic [31:0] cfg_data = '0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [95:0] s_tdata = '0;
    logic [2:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;
    logic        m_tuser;

    int idle_pct = 37;
    int mismatch_count = 0;
    int quiet_cycles = 0;

    // Predictor state: coefficient tables, written flags and configuration
    logic [23:0] samp_offset [SAMPLE_COUNT];
    logic [23:0] samp_gain   [SAMPLE_COUNT];
    logic [23:0] line_offset [LINE_COUNT];
    logic [23:0] line_gain   [LINE_COUNT];
    bit          samp_loaded [SAMPLE_COUNT];
    bit          line_loaded [LINE_COUNT];
    int          loaded_samples[$];
    int          loaded_lines[$];
    logic [31:0] scale_reg = prc_pkg::OUTPUT_SCALE_RESET;
    logic [14:0] good_line_reg = prc_pkg::LAST_GOOD_LINE_RESET;

    cal_result_t expected_pixels[$];

    pixel_radiometric_calibration dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Compute the calibrated Q24.8 value of one pixel, saturated to 32 bits
    function automatic logic [31:0] calibrate(input logic [10:0] s, input logic [14:0] l,
                                              input logic [15:0] dn);
        logic [14:0] row;
        logic signed [63:0] diff;
        logic [63:0] mag;
        logic [63:0] m1;
        logic [63:0] m2;
        logic [63:0] m3;
        logic neg;
        row = (l > good_line_reg) ? good_line_reg : l;
        diff = $signed({48'd0, dn} << 8) - 64'($signed(line_offset[row]))
               - 64'($signed(samp_offset[s]));
        neg = diff[63];
        mag = neg ? -diff : diff;
        m1 = (mag * 64'(line_gain[row]) + 64'h8000) >> 16;
        m2 = (m1 * 64'(samp_gain[s]) + 64'h8000) >> 16;
        m3 = m2 * 64'(scale_reg[31:16]) + ((m2 * 64'(scale_reg[15:0]) + 64'h8000) >> 16);
        if (neg)
            return (m3 > 64'h8000_0000) ? 32'h8000_0000 : 32'(-m3);
        return (m3 > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : m3[31:0];
    endfunction

    // Apply one accepted item to the predictor
    function automatic void track_item(input cal_item_t it);
        cal_result_t r;
        case (it.req)
            prc_pkg::REQ_SAMPLE:
            begin
                samp_offset[it.s] = it.offw;
                samp_gain[it.s] = it.gainw;
                if (!samp_loaded[it.s])
                begin
                    samp_loaded[it.s] = 1'b1;
                    loaded_samples.push_back(int'(it.s));
                end
            end
            prc_pkg::REQ_LINE:
            begin
                line_offset[it.l] = it.offw;
                line_gain[it.l] = it.gainw;
                if (!line_loaded[it.l])
                begin
                    line_loaded[it.l] = 1'b1;
                    loaded_lines.push_back(int'(it.l));
                end
            end
            prc_pkg::REQ_PIXEL:
            begin
                r.special = it.special;
                r.value = it.special ? {16'd0, it.dn} : calibrate(it.s, it.l, it.dn);
                expected_pixels.push_back(r);
            end
            default:
            begin
                // unused request code: no effect
            end
        endcase
    endfunction

    function automatic cal_item_t make_item(input logic [1:0] req, input logic [10:0] s,
                                            input logic [14:0] l, input logic [15:0] dn,
                                            input logic special, input logic [23:0] offw,
                                            input logic [23:0] gainw);
        cal_item_t it;
        it.req = req;
        it.s = s;
        it.l = l;
        it.dn = dn;
        it.special = special;
        it.offw = offw;
        it.gainw = gainw;
        return it;
    endfunction

    // Mostly small signed offsets, sometimes the full range
    function automatic logic [23:0] rand_offset();
        if ($urandom_range(3) == 0)
            return 24'($urandom);
        return 24'($urandom_range(40000)) - 24'd20000;
    endfunction

    // Mostly gains near 1.0, sometimes the full range
    function automatic logic [23:0] rand_gain();
        if ($urandom_range(3) == 0)
            return 24'($urandom);
        return 24'($urandom_range(24'h18000, 24'h8000));
    endfunction

    task automatic report_mismatch(input string msg);
        $display("ERROR at %0t: %s", $realtime, msg);
        mismatch_count++;
    endtask

    // Send one item after a random gap and update the predictor on acceptance
    task automatic send_item(input cal_item_t it);
        while ($urandom_range(99) < idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {6'd0, it.gainw, it.offw, it.dn, it.l, it.s};
        s_tuser <= {it.special, it.req};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        track_item(it);
    endtask

    // Stop sending, wait for every expected pixel, then let the pipe settle
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (expected_pixels.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Write both registers while the block is idle
    task automatic set_calibration(input logic [31:0] scale, input logic [14:0] good_line);
        cfg_we <= 1'b1;
        cfg_index <= prc_pkg::CFG_OUTPUT_SCALE;
        cfg_data <= scale;
        @(posedge clk);
        scale_reg = scale;
        cfg_index <= prc_pkg::CFG_LAST_GOOD_LINE;
        cfg_data <= {17'd0, good_line};
        @(posedge clk);
        good_line_reg = good_line;
        cfg_we <= 1'b0;
    endtask

    // Reconfigure, then make sure the clamp line has coefficients
    task automatic start_phase(input logic [31:0] scale, input logic [14:0] good_line);
        wait_idle();
        set_calibration(scale, good_line);
        send_item(make_item(prc_pkg::REQ_LINE, 11'($urandom), good_line, 16'($urandom),
                            1'($urandom), rand_offset(), rand_gain()));
    endtask

    // Random mix of loads, pixels on loaded entries, special pixels and unused codes
    task automatic run_traffic(input int count);
        cal_item_t it;
        int pick;
        repeat (count)
        begin
            pick = $urandom_range(99);
            it = make_item(prc_pkg::REQ_PIXEL, 11'($urandom), 15'($urandom), 16'($urandom),
                           1'($urandom), rand_offset(), rand_gain());
            if (pick < 12)
                it.req = prc_pkg::REQ_SAMPLE;
            else if (pick < 25)
                it.req = prc_pkg::REQ_LINE;
            else if (pick < 28)
                it.req = REQ_UNUSED;
            else if (pick < 36)
                it.special = 1'b1;
            else
            begin
                it.special = 1'b0;
                it.s = 11'(loaded_samples[$urandom_range(loaded_samples.size() - 1)]);
                if ($urandom_range(99) < 30)
                    it.l = 15'($urandom_range(32767, good_line_reg));
                else
                    it.l = 15'(loaded_lines[$urandom_range(loaded_lines.size() - 1)]);
            end
            send_item(it);
        end
    endtask

    // Field extremes, saturation, rounding ties, special and unused items at reset config
    task automatic test_directed_cases();
        send_item(make_item(prc_pkg::REQ_SAMPLE, 11'd0, 15'd0, 16'd0, 1'b0,
                            24'h000000, 24'h010000));
        send_item(make_item(prc_pkg::REQ_LINE, 11'd0, 15'd0, 16'd0, 1'b0,
                            24'h000000, 24'h010000));
        send_item(make_item(prc_pkg::REQ_PIXEL, 11'd0, 15'd0, 16'h0000, 1'b0, 24'd0, 24'd0));
        send_item(make_item(prc_pkg::REQ_PIXEL, 11'd0, 15'd0, 16'hFFFF, 1'b0, 24'd0, 24'd0));
        // positive saturation
        send_item(make_item(prc_pkg::REQ_SAMPLE, 11'd2047, 15'd0, 16'd0, 1'b0,
                            24'h800000, 24'hFFFFFF));
        send_item(make_item(prc_pkg::REQ_LINE, 11'd0, 15'd32767, 16'd0, 1'b0,
                            24'h7FFFFF, 24'hFFFFFF));
        send_item(make_item(prc_pkg::REQ_PIXEL, 11'd2047, 15'd32767, 16'hFFFF, 1'b0,
                            24'd0, 24'd0));
        // negative saturation
        send_item(make_item(prc_pkg::REQ_SAMPLE, 11'd1, 15'd0, 16'd0, 1'b1,
                            24'h7FFFFF, 24'hFFFFFF));
        send_item(make_item(prc_pkg::REQ_LINE, 11'd0, 15'd1, 16'd0, 1'b1,
                            24'h7FFFFF, 24'hFFFFFF));
        send_item(make_item(prc_pkg::REQ_PIXEL, 11'd1, 15'd1, 16'h0000, 1'b0, 24'd0, 24'd0));
        // rounding ties go away from zero, on both signs
        send_item(make_item(prc_pkg::REQ_SAMPLE, 11'd2, 15'd0, 16'd0, 1'b0,
                            24'h000001, 24'h010000));
        send_item(make_item(prc_pkg::REQ_LINE, 11'd0, 15'd2, 16'd0, 1'b0,
                            24'h000000, 24'h008000));
        send_item(make_item(prc_pkg::REQ_PIXEL, 11'd2, 15'd2, 16'h0000, 1'b0, 24'd0, 24'd0));
        send_item(make_item(prc_pkg::REQ_SAMPLE, 11'd3, 15'd0, 16'd0, 1'b0,
                            24'hFFFFFF, 24'h010000));
        send_item(make_item(prc_pkg::REQ_PIXEL, 11'd3, 15'd2, 16'h0000, 1'b0, 24'd0, 24'd0));
        // special pixels pass raw dn, tables untouched
        send_item(make_item(prc_pkg::REQ_PIXEL, 11'd2047, 15'd32767, 16'hFFFF, 1'b1,
                            24'hFFFFFF, 24'hFFFFFF));
        send_item(make_item(prc_pkg::REQ_PIXEL, 11'd1234, 15'd777, 16'h0000, 1'b1,
                            24'd0, 24'd0));
        // unused request code is dropped
        send_item(make_item(REQ_UNUSED, 11'h7FF, 15'h7FFF, 16'hFFFF, 1'b1, 24'hFFFFFF,
                            24'hFFFFFF));
        // zero line gain
        send_item(make_item(prc_pkg::REQ_LINE, 11'd0, 15'd3, 16'd0, 1'b0,
                            rand_offset(), 24'd0));
        send_item(make_item(prc_pkg::REQ_PIXEL, 11'd0, 15'd3, 16'($urandom), 1'b0,
                            24'd0, 24'd0));
    endtask

    // Scale and clamp line at their extremes
    task automatic test_config_extremes();
        start_phase(32'd0, 15'd0);
        run_traffic(250);
        start_phase(32'hFFFF_FFFF, 15'd32767);
        run_traffic(250);
    endtask

    // Random settings with random traffic
    task automatic test_random_traffic();
        repeat (3)
        begin
            start_phase(32'($urandom_range(32'h30000, 32'h4000)), 15'($urandom));
            run_traffic(300);
        end
    endtask

    // Full rate on both sides with an arbitrary scale
    task automatic test_back_to_back();
        start_phase(32'($urandom), 15'($urandom));
        idle_pct = 0;
        run_traffic(300);
        idle_pct = 37;
    endtask

    // Random output stall
    always @(posedge clk)
        m_tready <= ($urandom_range(99) >= idle_pct);

    // Check each result against the oldest expected pixel
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            if (expected_pixels.size() == 0)
                report_mismatch($sformatf("result with nothing expected: value %h special %b",
                                          m_tdata, m_tuser));
            else
            begin
                if (m_tdata !== expected_pixels[0].value)
                    report_mismatch($sformatf("calibrated_value got %h expected %h",
                                              m_tdata, expected_pixels[0].value));
                if (m_tuser !== expected_pixels[0].special)
                    report_mismatch($sformatf("passed_special got %b expected %b",
                                              m_tuser, expected_pixels[0].special));
                void'(expected_pixels.pop_front());
            end
        end
    end

    // Abort when no item moves on either side for too long
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("pixel_radiometric_calibration_test failed");
            $finish;
        end
    end

    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed_cases();
        test_config_extremes();
        test_random_traffic();
        test_back_to_back();
        wait_idle();
        if (mismatch_count == 0)
            $display("pixel_radiometric_calibration_test passed");
        else
            $display("pixel_radiometric_calibration_test failed");
        $finish;
    end

endmodule

>>> filelist.f
design/prc_pkg.sv
design/prc_coef_mem.sv
design/prc_calc.sv
design/pixel_radiometric_calibration.sv
sim/pixel_radiometric_calibration_test.sv
